// ===== rtl/assoc_lru_cache_tag_store_unit_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the lru tag store
// both macros expect clk and rst_n in the scope of the use site
// ---------------------------------------------------------------------------
`ifndef ASSOC_LRU_CACHE_TAG_STORE_UNIT_MACROS_SVH
`define ASSOC_LRU_CACHE_TAG_STORE_UNIT_MACROS_SVH

// property checked at every clock edge outside reset
`define ALRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ALRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/alru_pkg.sv =====
// ---------------------------------------------------------------------------
// alru_pkg
// shared widths, defaults, outcome codes and lookup kind for the tag store
// ---------------------------------------------------------------------------
package alru_pkg;

  // fixed field widths
  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 32;
  localparam int SLOT_W  = 2;
  localparam int OUTC_W  = 2;

  // default geometry
  localparam int WAYS_DEF        = 4;
  localparam int OFFSET_BITS_DEF = 4;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUT_HIT  = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_COLD = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_REPL = 2'd2;

  // lookup classification, exactly one member set
  typedef struct packed {
    logic hit;
    logic cold;
    logic repl;
  } alru_kind_t;

endpackage

// ===== rtl/alru_lookup.sv =====
// ---------------------------------------------------------------------------
// alru_lookup
// parallel tag compare, empty line search and victim pick for one access
// ---------------------------------------------------------------------------
module alru_lookup
  import alru_pkg::*;
#(
  parameter int WAYS  = WAYS_DEF,
  parameter int TAG_W = ADDR_W - OFFSET_BITS_DEF
) (
  input  logic [WAYS-1:0][TAG_W-1:0]          line_tag,
  input  logic [WAYS-1:0]                     line_valid,
  input  logic [WAYS-1:0][$clog2(WAYS)-1:0]   line_age,
  input  logic [TAG_W-1:0]                    req_tag,
  output alru_kind_t                          kind,
  output logic [$clog2(WAYS)-1:0]             way_idx
);

  localparam int IDX_W = $clog2(WAYS);
  localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(WAYS - 1);

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] empty;
  logic [WAYS-1:0] oldest;
  logic [WAYS-1:0] pick;
  logic            any_hit;
  logic            any_empty;

  // per-line compare and rank checks
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i]  = line_valid[i] && (line_tag[i] == req_tag);
      empty[i]  = !line_valid[i];
      oldest[i] = (line_age[i] == AGE_MAX);
    end
  end

  assign any_hit   = |match;
  assign any_empty = |empty;

  // choose the candidate set for this access
  always_comb begin
    priority if (any_hit) begin
      pick = match;
    end else if (any_empty) begin
      pick = empty;
    end else begin
      pick = oldest;
    end
  end

  // lowest-numbered line of the candidate set wins
  always_comb begin
    way_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (pick[i]) begin
        way_idx = IDX_W'(i);
      end
    end
  end

  assign kind.hit  = any_hit;
  assign kind.cold = !any_hit && any_empty;
  assign kind.repl = !any_hit && !any_empty;

endmodule

// ===== rtl/alru_lines.sv =====
// ---------------------------------------------------------------------------
// alru_lines
// line tags, valid bits and recency ranks with their per-access update
// ---------------------------------------------------------------------------
`include "assoc_lru_cache_tag_store_unit_macros.svh"

module alru_lines
  import alru_pkg::*;
#(
  parameter int WAYS  = WAYS_DEF,
  parameter int TAG_W = ADDR_W - OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  alru_kind_t                          kind,
  input  logic [$clog2(WAYS)-1:0]             way_idx,
  input  logic [TAG_W-1:0]                    req_tag,
  output logic [WAYS-1:0][TAG_W-1:0]          line_tag,
  output logic [WAYS-1:0]                     line_valid,
  output logic [WAYS-1:0][$clog2(WAYS)-1:0]   line_age
);

  localparam int IDX_W = $clog2(WAYS);
  localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(WAYS - 1);

  logic [WAYS-1:0][TAG_W-1:0] tag_r, tag_nxt;
  logic [WAYS-1:0]            valid_r, valid_nxt;
  logic [WAYS-1:0][IDX_W-1:0] age_r, age_nxt;
  logic [IDX_W-1:0]           sel_age;
  logic [WAYS-1:0]            oldest;

  assign sel_age = age_r[way_idx];

  // rank update: selected line becomes most recent, younger lines age
  always_comb begin
    tag_nxt   = tag_r;
    valid_nxt = valid_r;
    age_nxt   = age_r;
    if (go) begin
      for (int j = 0; j < WAYS; j++) begin
        if (IDX_W'(j) == way_idx) begin
          age_nxt[j]   = '0;
          valid_nxt[j] = 1'b1;
          if (!kind.hit) begin
            tag_nxt[j] = req_tag;
          end
        end else if (valid_r[j]) begin
          if (kind.cold) begin
            if (age_r[j] != AGE_MAX) begin
              age_nxt[j] = age_r[j] + 1'b1;
            end
          end else if (age_r[j] < sel_age) begin
            age_nxt[j] = age_r[j] + 1'b1;
          end
        end
      end
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      valid_r <= '0;
      age_r   <= '0;
    end else begin
      tag_r   <= tag_nxt;
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
    end
  end

  assign line_tag   = tag_r;
  assign line_valid = valid_r;
  assign line_age   = age_r;

  // lines holding the largest rank
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      oldest[i] = (age_r[i] == AGE_MAX);
    end
  end

  // once full the ranks form a permutation with a single victim
  `ALRU_ASSERT(a_one_oldest, (&valid_r) |-> $onehot(oldest), "full store lacks one oldest line")
  // a line once filled stays valid
  `ALRU_ASSERT(a_valid_sticky, $past(rst_n) |-> ((valid_r & $past(valid_r)) == $past(valid_r)), "valid line lost")
  // the touched line is most recent afterwards
  `ALRU_ASSERT_NEXT(a_mru_rank, go, (age_r[$past(way_idx)] == '0) && valid_r[$past(way_idx)], "touched line not most recent")

endmodule

// ===== rtl/alru_stats.sv =====
// ---------------------------------------------------------------------------
// alru_stats
// saturating access and hit counters, read directly as result fields
// ---------------------------------------------------------------------------
module alru_stats
  import alru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic             hit,
  input  logic             action,
  output logic [CNT_W-1:0] access_count,
  output logic [CNT_W-1:0] fetch_hit_count,
  output logic [CNT_W-1:0] load_hit_count
);

  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] fetch_r, fetch_nxt;
  logic [CNT_W-1:0] load_r,  load_nxt;

  // increments that stop at all ones
  always_comb begin
    total_nxt = total_r;
    fetch_nxt = fetch_r;
    load_nxt  = load_r;
    if (go) begin
      if (total_r != '1) begin
        total_nxt = total_r + 1'b1;
      end
      if (hit && !action && (fetch_r != '1)) begin
        fetch_nxt = fetch_r + 1'b1;
      end
      if (hit && action && (load_r != '1)) begin
        load_nxt = load_r + 1'b1;
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      fetch_r <= '0;
      load_r  <= '0;
    end else begin
      total_r <= total_nxt;
      fetch_r <= fetch_nxt;
      load_r  <= load_nxt;
    end
  end

  assign access_count    = total_r;
  assign fetch_hit_count = fetch_r;
  assign load_hit_count  = load_r;

endmodule

// ===== rtl/assoc_lru_cache_tag_store_unit.sv =====
// ---------------------------------------------------------------------------
// assoc_lru_cache_tag_store_unit
// fully associative tag store with lru replacement and hit statistics
// ---------------------------------------------------------------------------
// One access is taken per clock while busy is low; busy is high in reset
// and until the first edge that sees rst_n high. A taken access is held in
// the input register, then looked up and applied to the line state at the
// edge that also loads its result beat into the result register; the beat
// then sits on the out_ ports, marked by out_valid. The unit sustains one
// access per cycle, with a single compare-and-update pass between the input
// register and the result register. The receiver cannot stall, so every
// strobed beat must be taken in its cycle. The three counts are live
// registers and keep the last values between beats.
`include "assoc_lru_cache_tag_store_unit_macros.svh"

module assoc_lru_cache_tag_store_unit
  import alru_pkg::*;
#(
  parameter int WAYS        = WAYS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  output logic              out_hit,
  output logic [OUTC_W-1:0] out_outcome,
  output logic [SLOT_W-1:0] out_slot,
  output logic [CNT_W-1:0]  out_access_count,
  output logic [CNT_W-1:0]  out_fetch_hit_count,
  output logic [CNT_W-1:0]  out_load_hit_count
);

  localparam int TAG_W = ADDR_W - OFFSET_BITS;
  localparam int IDX_W = $clog2(WAYS);

  logic                       busy_r;
  logic                       in_valid_r;
  logic                       in_action_r;
  logic [TAG_W-1:0]           in_tag_r;
  logic                       accept;

  logic [WAYS-1:0][TAG_W-1:0] line_tag;
  logic [WAYS-1:0]            line_valid;
  logic [WAYS-1:0][IDX_W-1:0] line_age;
  alru_kind_t                 kind;
  logic [IDX_W-1:0]           way_idx;
  logic [OUTC_W-1:0]          outcome_nxt;

  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [OUTC_W-1:0]          out_outcome_r;
  logic [SLOT_W-1:0]          out_slot_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      in_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_action_r <= in_action;
      in_tag_r    <= in_address[ADDR_W-1:OFFSET_BITS];
    end
  end

  // tag compare and victim choice
  alru_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_lookup (
    .line_tag   (line_tag),
    .line_valid (line_valid),
    .line_age   (line_age),
    .req_tag    (in_tag_r),
    .kind       (kind),
    .way_idx    (way_idx)
  );

  // line state update
  alru_lines #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_lines (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (in_valid_r),
    .kind       (kind),
    .way_idx    (way_idx),
    .req_tag    (in_tag_r),
    .line_tag   (line_tag),
    .line_valid (line_valid),
    .line_age   (line_age)
  );

  // statistics
  alru_stats u_stats (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (in_valid_r),
    .hit             (kind.hit),
    .action          (in_action_r),
    .access_count    (out_access_count),
    .fetch_hit_count (out_fetch_hit_count),
    .load_hit_count  (out_load_hit_count)
  );

  // outcome code
  always_comb begin
    priority if (kind.hit) begin
      outcome_nxt = OUT_HIT;
    end else if (kind.cold) begin
      outcome_nxt = OUT_COLD;
    end else begin
      outcome_nxt = OUT_REPL;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_hit_r     <= kind.hit;
      out_outcome_r <= outcome_nxt;
      out_slot_r    <= SLOT_W'(way_idx);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_outcome = out_outcome_r;
  assign out_slot    = out_slot_r;

  // hit flag agrees with the outcome code
  `ALRU_ASSERT(a_hit_code, out_valid |-> (out_hit == (out_outcome == OUT_HIT)), "hit flag and outcome disagree")
  // outcome is one of the defined codes
  `ALRU_ASSERT(a_outcome_code, out_valid |-> (out_outcome == OUT_HIT || out_outcome == OUT_COLD || out_outcome == OUT_REPL), "undefined outcome code")
  // hit counts never pass the access count
  `ALRU_ASSERT(a_count_order, (out_fetch_hit_count <= out_access_count) && (out_load_hit_count <= out_access_count), "hit count above access count")
  // each looked-up access falls in exactly one class
  `ALRU_ASSERT(a_kind_onehot, in_valid_r |-> $onehot(kind), "lookup kind not one-hot")

endmodule
